FILE: hw/rtl/keyed_add_rotate_byte_cipher_core_defines.svh
// Assertion macros shared by the RTL.
`ifndef KEYED_ADD_ROTATE_BYTE_CIPHER_CORE_DEFINES_SVH
`define KEYED_ADD_ROTATE_BYTE_CIPHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define KARBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define KARBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KARBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define KARBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/karbc_pkg.sv
package karbc_pkg;

    localparam int unsigned ROUND_COUNT = 8;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SHIFT_W     = 3;
    localparam int unsigned ADDS_W      = ROUND_COUNT * BYTE_W;
    localparam int unsigned SHIFTS_W    = ROUND_COUNT * SHIFT_W;
    localparam int unsigned CFG_DATA_W  = ADDS_W;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [SHIFT_W-1:0] t_shift;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIRECTION    = 2'd0,
        CFG_ROUND_ADDS   = 2'd1,
        CFG_ROUND_SHIFTS = 2'd2
    } t_cfg_index;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_direction;

    function automatic t_byte rotl(input t_byte v, input t_shift s);
        logic [2*BYTE_W-1:0] t;
        t = {v, v} << s;
        return t[2*BYTE_W-1:BYTE_W];
    endfunction

    function automatic t_byte rotr(input t_byte v, input t_shift s);
        logic [2*BYTE_W-1:0] t;
        t = {v, v} >> s;
        return t[BYTE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/karbc_rounds.sv
module karbc_rounds (
    input  logic                              i_direction,
    input  logic [karbc_pkg::ADDS_W-1:0]      i_round_adds,
    input  logic [karbc_pkg::SHIFTS_W-1:0]    i_round_shifts,
    input  karbc_pkg::t_byte                  i_data_byte,
    input  karbc_pkg::t_byte                  i_chain_byte,
    output karbc_pkg::t_byte                  o_result_byte,
    output karbc_pkg::t_byte                  o_next_chain
);

    karbc_pkg::t_byte w_enc;
    karbc_pkg::t_byte w_dec;

    // Encode: whiten with chain, add key byte 0, then seven rotate/add rounds.
    always_comb begin
        karbc_pkg::t_byte v;
        v = (i_data_byte ^ i_chain_byte) + i_round_adds[karbc_pkg::BYTE_W-1:0];
        for (int i = 1; i < karbc_pkg::ROUND_COUNT; i++) begin
            v = karbc_pkg::rotl(v, i_round_shifts[karbc_pkg::SHIFT_W*i +: karbc_pkg::SHIFT_W])
                + i_round_adds[karbc_pkg::BYTE_W*i +: karbc_pkg::BYTE_W];
        end
        w_enc = v;
    end

    // Decode: undo rounds last to first, then strip key byte 0 and chain.
    always_comb begin
        karbc_pkg::t_byte v;
        v = i_data_byte;
        for (int i = karbc_pkg::ROUND_COUNT - 1; i >= 1; i--) begin
            v = karbc_pkg::rotr(v - i_round_adds[karbc_pkg::BYTE_W*i +: karbc_pkg::BYTE_W],
                                i_round_shifts[karbc_pkg::SHIFT_W*i +: karbc_pkg::SHIFT_W]);
        end
        w_dec = (v - i_round_adds[karbc_pkg::BYTE_W-1:0]) ^ i_chain_byte;
    end

    always_comb begin
        if (i_direction == karbc_pkg::DIR_DECODE) begin
            o_result_byte = w_dec;
            o_next_chain  = i_data_byte;
        end else begin
            o_result_byte = w_enc;
            o_next_chain  = w_enc;
        end
    end

endmodule

FILE: hw/rtl/keyed_add_rotate_byte_cipher_core.sv
// Byte-chained keyed add/rotate scrambler. Each transaction carries one byte;
// a set packet_start reloads the chain byte from seed before that byte is
// processed. The block is a two-register pipeline (input register, result
// register) with the key byte 0 add, the seven rotate/add rounds and the chain
// feedback combinational between them: one byte per cycle sustained while the
// output is not stalled. Configuration (direction, round adds, round shifts)
// is to be written through the plain write port while no transaction is in
// flight (not enforced by the block); writes to an unused index are dropped.
`include "keyed_add_rotate_byte_cipher_core_defines.svh"

module keyed_add_rotate_byte_cipher_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [karbc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [karbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  karbc_pkg::t_byte                    i_data_byte,
    input  logic                                i_packet_start,
    input  karbc_pkg::t_byte                    i_seed,
    output logic                                o_valid,
    input  logic                                i_ready,
    output karbc_pkg::t_byte                    o_result_byte
);

    logic                               r_direction;
    logic [karbc_pkg::ADDS_W-1:0]       r_round_adds;
    logic [karbc_pkg::SHIFTS_W-1:0]     r_round_shifts;

    logic                               r_in_valid;
    karbc_pkg::t_byte                   r_in_data;
    logic                               r_in_start;
    karbc_pkg::t_byte                   r_in_seed;

    logic                               r_out_valid;
    karbc_pkg::t_byte                   r_result;
    karbc_pkg::t_byte                   r_chain;

    logic                               w_advance;
    logic                               w_accept;
    karbc_pkg::t_byte                   w_chain_in;
    karbc_pkg::t_byte                   w_result;
    karbc_pkg::t_byte                   w_next_chain;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= 1'b0;
            r_round_adds   <= '0;
            r_round_shifts <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                karbc_pkg::CFG_DIRECTION:    r_direction    <= i_cfg_data[0];
                karbc_pkg::CFG_ROUND_ADDS:   r_round_adds   <= i_cfg_data[karbc_pkg::ADDS_W-1:0];
                karbc_pkg::CFG_ROUND_SHIFTS: r_round_shifts <= i_cfg_data[karbc_pkg::SHIFTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Move the held byte to the result register when that slot frees up.
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data  <= i_data_byte;
            r_in_start <= i_packet_start;
            r_in_seed  <= i_seed;
        end
    end

    assign w_chain_in = r_in_start ? r_in_seed : r_chain;

    karbc_rounds u_rounds (
        .i_direction    (r_direction),
        .i_round_adds   (r_round_adds),
        .i_round_shifts (r_round_shifts),
        .i_data_byte    (r_in_data),
        .i_chain_byte   (w_chain_in),
        .o_result_byte  (w_result),
        .o_next_chain   (w_next_chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_chain     <= w_next_chain;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_byte = r_result;

    `KARBC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_advance, r_out_valid, "result slot empty after advance")
    `KARBC_ASSERT_NEXT(a_chain_holds, i_clk, i_rst_n, !w_advance, $stable(r_chain), "chain byte moved without a transaction")
    `KARBC_ASSERT_NEXT(a_enc_chain, i_clk, i_rst_n, w_advance && !r_direction, r_chain == r_result, "encode chain differs from result")
    `KARBC_ASSERT_NEXT(a_dec_chain, i_clk, i_rst_n, w_advance && r_direction, r_chain == $past(r_in_data), "decode chain differs from ciphertext")
    `KARBC_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_ready, r_in_valid && r_out_valid, "input stalled with a free slot")

endmodule
